// File: src/srr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_pkg: shared types and constants for the refraction block
// Beat formats, status codes and fixed-point widths used across the design.
// ----------------------------------------------------------------------------
package srr_pkg;

    // default output fraction bits (Q1.14)
    localparam int OUT_FRAC_DEF = 14;
    // internal unit vectors are Q2.30
    localparam int WORK_FRAC    = 30;
    localparam int UNIT_W       = WORK_FRAC + 2;
    localparam int VEC_W        = 16;
    localparam int IDX_W        = 16;
    // depth of the queue between front and back
    localparam int QDEPTH       = 4;

    typedef enum logic [1:0] {
        ST_REFRACT = 2'd0,
        ST_TIR     = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [VEC_W-1:0] dir_x;
        logic signed [VEC_W-1:0] dir_y;
        logic signed [VEC_W-1:0] dir_z;
        logic signed [VEC_W-1:0] normal_x;
        logic signed [VEC_W-1:0] normal_y;
        logic signed [VEC_W-1:0] normal_z;
        logic [IDX_W-1:0]        index_in;
        logic [IDX_W-1:0]        index_out;
    } t_ray_in;

    typedef struct packed {
        t_status            status;
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
    } t_ray_out;

    // classified ray handed from front to back
    typedef struct packed {
        logic                    invalid;
        logic [IDX_W-1:0]        index_in;
        logic [IDX_W-1:0]        index_out;
        logic [2:0][UNIT_W-1:0]  du;
        logic [2:0][UNIT_W-1:0]  nu;
    } t_mid;

endpackage

// File: src/snell_refract_or_reflect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snell_refract_or_reflect: vector Snell refraction with TIR detection
// Normalizes ray and normal, reports refracted or mirrored unit direction.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive i_ray and raise start; a ray beat is taken on each rising
//   edge with start high and busy low. busy comes from the internal queue
//   and stays low in operation since the back end drains it every cycle.
//   Output: o_valid marks o_ray for exactly one cycle; the receiver must
//   take it then, it cannot hold results off.
//   Throughput: one ray per clock, fully pipelined.
//   Pipeline: from accept to o_valid a ray passes three square-root
//   pipelines in series (one bit per stage), the restoring dividers of the
//   two normalizers (one quotient bit per stage) and the queue's storage
//   and registered read.
//   Status: ST_REFRACT, ST_TIR or ST_INVALID (zero index or zero vector,
//   direction then zero).
//   Reset: synchronous, active low; clears all valid bits and the queue.
//   In-flight rays are dropped.
// ----------------------------------------------------------------------------
module snell_refract_or_reflect
    import srr_pkg::*;
#(
    parameter int OUT_FRAC_BITS = OUT_FRAC_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_ray_in  i_ray,
    output logic     busy,
    output logic     o_valid,
    output t_ray_out o_ray
);

    logic w_accept;
    logic w_fvld;
    t_mid w_fmid;
    logic w_qvld;
    t_mid w_qmid;
    logic w_full;

    assign w_accept = start & ~busy;
    assign busy     = w_full;

    srr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_accept),
        .i_ray   (i_ray),
        .o_vld   (w_fvld),
        .o_mid   (w_fmid)
    );

    srr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fvld),
        .i_data  (w_fmid),
        .o_vld   (w_qvld),
        .o_data  (w_qmid),
        .o_full  (w_full)
    );

    srr_back #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_qvld),
        .i_mid   (w_qmid),
        .o_vld   (o_valid),
        .o_ray   (o_ray)
    );

endmodule

// File: src/srr_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_isqrt: pipelined floor integer square root
// One root bit per stage, remainder kept as x - root^2; sideband rides along.
// ----------------------------------------------------------------------------
module srr_isqrt #(
    parameter int XW = 64,
    parameter int PW = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  logic [XW-1:0]      i_x,
    input  logic [PW-1:0]      i_pay,
    output logic               o_vld,
    output logic [XW/2-1:0]    o_root,
    output logic [PW-1:0]      o_pay
);

    localparam int RW = XW / 2;

    logic              s_vld  [0:RW];
    logic [XW-1:0]     s_rem  [0:RW];
    logic [RW-1:0]     s_root [0:RW];
    logic [PW-1:0]     s_pay  [0:RW];

    assign s_vld[0]  = i_vld;
    assign s_rem[0]  = i_x;
    assign s_root[0] = '0;
    assign s_pay[0]  = i_pay;

    // one stage per result bit, MSB first
    for (genvar k = 0; k < RW; k++) begin : g_stage
        localparam int B = RW - 1 - k;
        logic [XW+1:0] w_trial;
        logic          r_vld;
        logic [XW-1:0] r_rem;
        logic [RW-1:0] r_root;
        logic [PW-1:0] r_pay;

        // (root + 2^B)^2 - root^2
        assign w_trial = ((XW+2)'(s_root[k]) << (B + 1)) | ((XW+2)'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= s_vld[k];
            end
            r_pay <= s_pay[k];
            if ({2'b00, s_rem[k]} >= w_trial) begin
                r_rem  <= s_rem[k] - w_trial[XW-1:0];
                r_root <= s_root[k] | (RW'(1) << B);
            end else begin
                r_rem  <= s_rem[k];
                r_root <= s_root[k];
            end
        end

        assign s_vld[k+1]  = r_vld;
        assign s_rem[k+1]  = r_rem;
        assign s_root[k+1] = r_root;
        assign s_pay[k+1]  = r_pay;
    end

    assign o_vld  = s_vld[RW];
    assign o_root = s_root[RW];
    assign o_pay  = s_pay[RW];

endmodule

// File: src/srr_unitize.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_unitize: pipelined 3-vector normalizer
// Scales magnitudes to [2^30, 2^31), takes the length by isqrt, then divides
// each component by the length one quotient bit per stage, rounded.
// ----------------------------------------------------------------------------
module srr_unitize #(
    parameter int IW   = 16,
    parameter int FRAC = 30,
    parameter int PW   = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_vld,
    input  logic signed [IW-1:0]   i_x,
    input  logic signed [IW-1:0]   i_y,
    input  logic signed [IW-1:0]   i_z,
    input  logic [PW-1:0]          i_pay,
    output logic                   o_vld,
    output logic                   o_nz,
    output logic signed [FRAC+1:0] o_ux,
    output logic signed [FRAC+1:0] o_uy,
    output logic signed [FRAC+1:0] o_uz,
    output logic [PW-1:0]          o_pay
);

    localparam int NW  = 31;               // normalized magnitude bits
    localparam int LW  = NW + 1;           // length bits
    localparam int SW  = $clog2(IW + 1);
    localparam int QW  = FRAC + 1;
    localparam int DN  = FRAC + 1;         // divider stages
    localparam int NMW = NW + FRAC + 1;    // rounded numerator bits
    localparam int XPW = PW + 3 + 3 * NW + 1;

    typedef struct packed {
        logic                  vld;
        logic                  nz;
        logic [2:0]            neg;
        logic [LW-1:0]         len;
        logic [2:0][LW:0]      rem;
        logic [2:0][FRAC:0]    nlo;
        logic [2:0][QW-1:0]    q;
        logic [PW-1:0]         pay;
    } t_div;

    // stage 1: magnitudes and largest
    logic [2:0][IW-1:0] w_mag;
    logic               r1_vld;
    logic [2:0][IW-1:0] r1_mag;
    logic [2:0]         r1_neg;
    logic [IW-1:0]      r1_top;
    logic [PW-1:0]      r1_pay;

    always_comb begin
        w_mag[0] = i_x[IW-1] ? IW'(-i_x) : IW'(i_x);
        w_mag[1] = i_y[IW-1] ? IW'(-i_y) : IW'(i_y);
        w_mag[2] = i_z[IW-1] ? IW'(-i_z) : IW'(i_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
        end
        r1_mag <= w_mag;
        r1_neg <= {i_z[IW-1], i_y[IW-1], i_x[IW-1]};
        r1_pay <= i_pay;
        if (w_mag[0] >= w_mag[1] && w_mag[0] >= w_mag[2]) begin
            r1_top <= w_mag[0];
        end else if (w_mag[1] >= w_mag[2]) begin
            r1_top <= w_mag[1];
        end else begin
            r1_top <= w_mag[2];
        end
    end

    // stage 2: leading one of the largest sets the shift
    logic [SW-1:0]      w_sh;
    logic               r2_vld;
    logic               r2_nz;
    logic [SW-1:0]      r2_sh;
    logic [2:0][IW-1:0] r2_mag;
    logic [2:0]         r2_neg;
    logic [PW-1:0]      r2_pay;

    always_comb begin
        w_sh = '0;
        for (int j = 0; j < IW; j++) begin
            if (r1_top[j]) begin
                w_sh = SW'(j + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_nz  <= (r1_top != '0);
        r2_sh  <= w_sh;
        r2_mag <= r1_mag;
        r2_neg <= r1_neg;
        r2_pay <= r1_pay;
    end

    // stage 3: shift so the largest lies in [2^30, 2^31), truncating
    logic [2:0][IW+NW-1:0] w_ext;
    logic                  r3_vld;
    logic                  r3_nz;
    logic [2:0][NW-1:0]    r3_mn;
    logic [2:0]            r3_neg;
    logic [PW-1:0]         r3_pay;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_ext[i] = {r2_mag[i], {NW{1'b0}}} >> r2_sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        r3_nz  <= r2_nz;
        r3_neg <= r2_neg;
        r3_pay <= r2_pay;
        for (int i = 0; i < 3; i++) begin
            r3_mn[i] <= w_ext[i][NW-1:0];
        end
    end

    // stage 4: squares
    logic                 r4_vld;
    logic                 r4_nz;
    logic [2:0][2*NW-1:0] r4_sq;
    logic [2:0][NW-1:0]   r4_mn;
    logic [2:0]           r4_neg;
    logic [PW-1:0]        r4_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
        r4_nz  <= r3_nz;
        r4_mn  <= r3_mn;
        r4_neg <= r3_neg;
        r4_pay <= r3_pay;
        for (int i = 0; i < 3; i++) begin
            r4_sq[i] <= (2*NW)'(r3_mn[i]) * (2*NW)'(r3_mn[i]);
        end
    end

    // stage 5: sum of squares
    logic                 r5_vld;
    logic [2*NW+1:0]      r5_sum;
    logic [XPW-1:0]       r5_xpay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
        r5_sum  <= (2*NW+2)'(r4_sq[0]) + (2*NW+2)'(r4_sq[1]) + (2*NW+2)'(r4_sq[2]);
        r5_xpay <= {r4_pay, r4_neg, r4_mn, r4_nz};
    end

    // length
    logic               w_lvld;
    logic [LW-1:0]      w_len;
    logic [XPW-1:0]     w_lpay;
    logic [PW-1:0]      w_pay_l;
    logic [2:0]         w_neg_l;
    logic [2:0][NW-1:0] w_mn_l;
    logic               w_nz_l;

    srr_isqrt #(
        .XW (2 * NW + 2),
        .PW (XPW)
    ) u_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r5_vld),
        .i_x     (r5_sum),
        .i_pay   (r5_xpay),
        .o_vld   (w_lvld),
        .o_root  (w_len),
        .o_pay   (w_lpay)
    );

    assign {w_pay_l, w_neg_l, w_mn_l, w_nz_l} = w_lpay;

    // divider setup: numerator m*2^F + len/2, upper part preloaded as remainder
    t_div s_div [0:DN];
    t_div n_d0;
    t_div r_d0;

    always_comb begin
        logic [NMW-1:0] num;
        n_d0     = '0;
        n_d0.vld = w_lvld;
        n_d0.nz  = w_nz_l;
        n_d0.neg = w_neg_l;
        n_d0.len = w_len;
        n_d0.pay = w_pay_l;
        for (int i = 0; i < 3; i++) begin
            num         = {w_mn_l[i], {FRAC{1'b0}}} + NMW'(w_len >> 1);
            n_d0.rem[i] = (LW+1)'(num >> (FRAC + 1));
            n_d0.nlo[i] = num[FRAC:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d0 <= '0;
        end else begin
            r_d0 <= n_d0;
        end
    end

    assign s_div[0] = r_d0;

    // one quotient bit per stage for all three components
    for (genvar k = 0; k < DN; k++) begin : g_div
        t_div n_d;
        t_div r_d;

        always_comb begin
            logic [LW:0] t;
            n_d = s_div[k];
            for (int i = 0; i < 3; i++) begin
                t = {s_div[k].rem[i][LW-1:0], s_div[k].nlo[i][FRAC]};
                n_d.nlo[i] = {s_div[k].nlo[i][FRAC-1:0], 1'b0};
                if (t >= {1'b0, s_div[k].len}) begin
                    n_d.rem[i] = t - {1'b0, s_div[k].len};
                    n_d.q[i]   = {s_div[k].q[i][QW-2:0], 1'b1};
                end else begin
                    n_d.rem[i] = t;
                    n_d.q[i]   = {s_div[k].q[i][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d <= '0;
            end else begin
                r_d <= n_d;
            end
        end

        assign s_div[k+1] = r_d;
    end

    // final: clamp to one, apply sign, zero for a zero vector
    logic signed [2:0][FRAC+1:0] w_u;
    logic                        r_vld;
    logic                        r_nz;
    logic [2:0][FRAC+1:0]        r_u;
    logic [PW-1:0]               r_pay;

    always_comb begin
        logic [QW-1:0] q;
        for (int i = 0; i < 3; i++) begin
            q = s_div[DN].q[i];
            if (q > (QW'(1) << FRAC)) begin
                q = QW'(1) << FRAC;
            end
            if (!s_div[DN].nz) begin
                w_u[i] = '0;
            end else if (s_div[DN].neg[i]) begin
                w_u[i] = -$signed({1'b0, q});
            end else begin
                w_u[i] = $signed({1'b0, q});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= s_div[DN].vld;
        end
        r_nz  <= s_div[DN].nz;
        r_u   <= w_u;
        r_pay <= s_div[DN].pay;
    end

    assign o_vld = r_vld;
    assign o_nz  = r_nz;
    assign o_ux  = $signed(r_u[0]);
    assign o_uy  = $signed(r_u[1]);
    assign o_uz  = $signed(r_u[2]);
    assign o_pay = r_pay;

endmodule

// File: src/srr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_front: accept side of the refraction block
// Normalizes direction and normal in parallel and flags invalid rays.
// ----------------------------------------------------------------------------
module srr_front
    import srr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_vld,
    input  t_ray_in i_ray,
    output logic    o_vld,
    output t_mid    o_mid
);

    logic                     w_dvld;
    logic                     w_dnz;
    logic signed [UNIT_W-1:0] w_dx, w_dy, w_dz;
    logic [IDX_W-1:0]         w_ni;
    logic                     w_nvld;
    logic                     w_nnz;
    logic signed [UNIT_W-1:0] w_nx, w_ny, w_nz;
    logic [IDX_W-1:0]         w_no;
    logic                     r_vld;
    t_mid                     r_mid;

    // direction path carries index_in
    srr_unitize #(
        .IW   (VEC_W),
        .FRAC (WORK_FRAC),
        .PW   (IDX_W)
    ) u_dir (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_vld),
        .i_x     (i_ray.dir_x),
        .i_y     (i_ray.dir_y),
        .i_z     (i_ray.dir_z),
        .i_pay   (i_ray.index_in),
        .o_vld   (w_dvld),
        .o_nz    (w_dnz),
        .o_ux    (w_dx),
        .o_uy    (w_dy),
        .o_uz    (w_dz),
        .o_pay   (w_ni)
    );

    // normal path carries index_out
    srr_unitize #(
        .IW   (VEC_W),
        .FRAC (WORK_FRAC),
        .PW   (IDX_W)
    ) u_nrm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_vld),
        .i_x     (i_ray.normal_x),
        .i_y     (i_ray.normal_y),
        .i_z     (i_ray.normal_z),
        .i_pay   (i_ray.index_out),
        .o_vld   (w_nvld),
        .o_nz    (w_nnz),
        .o_ux    (w_nx),
        .o_uy    (w_ny),
        .o_uz    (w_nz),
        .o_pay   (w_no)
    );

    // classify
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= w_dvld & w_nvld;
        end
        r_mid.invalid   <= (w_ni == '0) || (w_no == '0) || !w_dnz || !w_nnz;
        r_mid.index_in  <= w_ni;
        r_mid.index_out <= w_no;
        r_mid.du        <= {w_dz, w_dy, w_dx};
        r_mid.nu        <= {w_nz, w_ny, w_nx};
    end

    assign o_vld = r_vld;
    assign o_mid = r_mid;

endmodule

// File: src/srr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_queue: short queue between front and back
// Drains one beat per cycle whenever it holds one; read data registered.
// ----------------------------------------------------------------------------
module srr_queue
    import srr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_mid i_data,
    output logic o_vld,
    output t_mid o_data,
    output logic o_full
);

    localparam int AW = $clog2(QDEPTH);

    t_mid          r_mem [QDEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_count;
    logic          r_vld;
    t_mid          r_data;
    logic          w_pop;

    assign w_pop = (r_count != '0);

    // storage and registered read
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
        r_data <= r_mem[r_rd];
    end

    // pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
            r_vld   <= 1'b0;
        end else begin
            r_vld <= w_pop;
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;
    assign o_full = (r_count >= (AW+1)'(QDEPTH - 1));

endmodule

// File: src/srr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_back: execute side of the refraction block
// Cosine, TIR test, transmitted root, outgoing vector and its normalization.
// ----------------------------------------------------------------------------
module srr_back
    import srr_pkg::*;
#(
    parameter int OUT_FRAC_BITS = OUT_FRAC_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_vld,
    input  t_mid     i_mid,
    output logic     o_vld,
    output t_ray_out o_ray
);

    localparam int CW = WORK_FRAC + 1;   // cosine bits
    localparam int WW = 37;              // outgoing vector bits
    localparam int KW = 36;              // mirror/refract coefficient bits

    typedef struct packed {
        logic                   invalid;
        logic                   tir;
        logic [IDX_W-1:0]       ni;
        logic [IDX_W+CW-1:0]    nic;
        logic [CW-1:0]          c;
        logic [2:0][UNIT_W-1:0] du;
        logic [2:0][UNIT_W-1:0] mo;
    } t_bctx;

    // signed shift right, rounding half away from zero
    function automatic logic signed [71:0] rnd_shr(input logic signed [71:0] x,
                                                   input int unsigned sh);
        logic [71:0] m;
        m = x[71] ? 72'(-x) : 72'(x);
        m = (m + (72'(1) << (sh - 1))) >> sh;
        return x[71] ? -$signed(m) : $signed(m);
    endfunction

    // b1: dot product terms
    logic                    r1_vld;
    t_mid                    r1_mid;
    logic signed [63:0]      r1_p [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
        end
        r1_mid <= i_mid;
        for (int i = 0; i < 3; i++) begin
            r1_p[i] <= 64'($signed(i_mid.du[i]) * $signed(i_mid.nu[i]));
        end
    end

    // b2: dot product
    logic               r2_vld;
    t_mid               r2_mid;
    logic signed [63:0] r2_dot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_mid <= r1_mid;
        r2_dot <= r1_p[0] + r1_p[1] + r1_p[2];
    end

    // b3: orient normal against the ray, rounded cosine clamped to one
    logic [63:0]            w_magd;
    logic [33:0]            w_c34;
    logic                   r3_vld;
    t_mid                   r3_mid;
    logic [CW-1:0]          r3_c;
    logic [2:0][UNIT_W-1:0] r3_mo;

    always_comb begin
        w_magd = r2_dot[63] ? 64'(-r2_dot) : 64'(r2_dot);
        w_c34  = 34'((w_magd + (64'(1) << (WORK_FRAC - 1))) >> WORK_FRAC);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        r3_mid <= r2_mid;
        if (w_c34 > (34'(1) << WORK_FRAC)) begin
            r3_c <= CW'(1) << WORK_FRAC;
        end else begin
            r3_c <= w_c34[CW-1:0];
        end
        for (int i = 0; i < 3; i++) begin
            if (r2_dot > 0) begin
                r3_mo[i] <= UNIT_W'(-$signed(r2_mid.nu[i]));
            end else begin
                r3_mo[i] <= r2_mid.nu[i];
            end
        end
    end

    // b4: squares and ni*c
    logic                   r4_vld;
    t_mid                   r4_mid;
    logic [CW-1:0]          r4_c;
    logic [2:0][UNIT_W-1:0] r4_mo;
    logic [2*CW-1:0]        r4_c2;
    logic [2*IDX_W-1:0]     r4_ni2;
    logic [2*IDX_W-1:0]     r4_no2;
    logic [IDX_W+CW-1:0]    r4_nic;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
        r4_mid <= r3_mid;
        r4_c   <= r3_c;
        r4_mo  <= r3_mo;
        r4_c2  <= (2*CW)'(r3_c) * (2*CW)'(r3_c);
        r4_ni2 <= (2*IDX_W)'(r3_mid.index_in) * (2*IDX_W)'(r3_mid.index_in);
        r4_no2 <= (2*IDX_W)'(r3_mid.index_out) * (2*IDX_W)'(r3_mid.index_out);
        r4_nic <= (IDX_W+CW)'(r3_mid.index_in) * (IDX_W+CW)'(r3_c);
    end

    // b5: sin^2 in Q30, index_out^2 aligned
    logic [2*CW-1:0]        w_s62;
    logic                   r5_vld;
    t_mid                   r5_mid;
    logic [CW-1:0]          r5_c;
    logic [2:0][UNIT_W-1:0] r5_mo;
    logic [CW-1:0]          r5_s30;
    logic [2*IDX_W-1:0]     r5_ni2;
    logic [61:0]            r5_no2s;
    logic [IDX_W+CW-1:0]    r5_nic;

    assign w_s62 = ((2*CW)'(1) << (2 * WORK_FRAC)) - r4_c2
                   + ((2*CW)'(1) << (WORK_FRAC - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
        r5_mid  <= r4_mid;
        r5_c    <= r4_c;
        r5_mo   <= r4_mo;
        r5_s30  <= w_s62[WORK_FRAC+CW-1:WORK_FRAC];
        r5_ni2  <= r4_ni2;
        r5_no2s <= {r4_no2, {WORK_FRAC{1'b0}}};
        r5_nic  <= r4_nic;
    end

    // b6: index_in^2 * sin^2
    logic                   r6_vld;
    t_mid                   r6_mid;
    logic [CW-1:0]          r6_c;
    logic [2:0][UNIT_W-1:0] r6_mo;
    logic [62:0]            r6_lhs;
    logic [61:0]            r6_no2s;
    logic [IDX_W+CW-1:0]    r6_nic;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= r5_vld;
        end
        r6_mid  <= r5_mid;
        r6_c    <= r5_c;
        r6_mo   <= r5_mo;
        r6_lhs  <= 63'(r5_ni2) * 63'(r5_s30);
        r6_no2s <= r5_no2s;
        r6_nic  <= r5_nic;
    end

    // b7: TIR test and radicand for index_out*cos_t
    logic        w_over;
    logic        r7_vld;
    logic [61:0] r7_k2;
    t_bctx       r7_ctx;

    assign w_over = r6_lhs > {1'b0, r6_no2s};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else begin
            r7_vld <= r6_vld;
        end
        r7_k2          <= w_over ? '0 : r6_no2s - r6_lhs[61:0];
        r7_ctx.invalid <= r6_mid.invalid;
        r7_ctx.tir     <= (r6_mid.index_in > r6_mid.index_out) && w_over;
        r7_ctx.ni      <= r6_mid.index_in;
        r7_ctx.nic     <= r6_nic;
        r7_ctx.c       <= r6_c;
        r7_ctx.du      <= r6_mid.du;
        r7_ctx.mo      <= r6_mo;
    end

    logic          w_rvld;
    logic [30:0]   w_root;
    t_bctx         w_rctx;

    srr_isqrt #(
        .XW (62),
        .PW ($bits(t_bctx))
    ) u_cost (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r7_vld),
        .i_x     (r7_k2),
        .i_pay   (r7_ctx),
        .o_vld   (w_rvld),
        .o_root  (w_root),
        .o_pay   (w_rctx)
    );

    // b8: coefficient on the oriented normal
    logic signed [48:0] w_coeff;
    logic signed [KW-1:0] w_coeff30;
    logic               r8_vld;
    t_bctx              r8_ctx;
    logic signed [KW-1:0] r8_k;

    always_comb begin
        w_coeff   = $signed({2'b00, w_rctx.nic}) - $signed({3'b000, w_root, 15'd0});
        w_coeff30 = KW'(rnd_shr(72'(w_coeff), 13));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else begin
            r8_vld <= w_rvld;
        end
        r8_ctx <= w_rctx;
        r8_k   <= w_rctx.tir ? $signed({{(KW-CW-1){1'b0}}, w_rctx.c, 1'b0}) : w_coeff30;
    end

    // b9: products
    logic               r9_vld;
    t_bctx              r9_ctx;
    logic signed [67:0] r9_p2 [3];
    logic signed [48:0] r9_p1 [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_vld <= 1'b0;
        end else begin
            r9_vld <= r8_vld;
        end
        r9_ctx <= r8_ctx;
        for (int i = 0; i < 3; i++) begin
            r9_p2[i] <= 68'(r8_k * $signed(r8_ctx.mo[i]));
            r9_p1[i] <= 49'($signed({1'b0, r8_ctx.ni}) * $signed(r8_ctx.du[i]));
        end
    end

    // b10: outgoing vector, mirror or refraction
    logic signed [WW-1:0] w_t1 [3];
    logic signed [WW-1:0] w_t2 [3];
    logic                 r10_vld;
    logic                 r10_inv;
    logic                 r10_tir;
    logic signed [WW-1:0] r10_w [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r9_ctx.tir) begin
                w_t1[i] = WW'($signed(r9_ctx.du[i]));
            end else begin
                w_t1[i] = WW'(rnd_shr(72'(r9_p1[i]), 13));
            end
            w_t2[i] = WW'(rnd_shr(72'(r9_p2[i]), WORK_FRAC));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_vld <= 1'b0;
        end else begin
            r10_vld <= r9_vld;
        end
        r10_inv <= r9_ctx.invalid;
        r10_tir <= r9_ctx.tir;
        for (int i = 0; i < 3; i++) begin
            r10_w[i] <= w_t1[i] + w_t2[i];
        end
    end

    // normalize to the output format
    logic                          w_uvld;
    logic                          w_unz;
    logic signed [OUT_FRAC_BITS+1:0] w_ux, w_uy, w_uz;
    logic [1:0]                    w_upay;
    logic                          r_vld;
    t_ray_out                      r_ray;

    srr_unitize #(
        .IW   (WW),
        .FRAC (OUT_FRAC_BITS),
        .PW   (2)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r10_vld),
        .i_x     (r10_w[0]),
        .i_y     (r10_w[1]),
        .i_z     (r10_w[2]),
        .i_pay   ({r10_inv, r10_tir}),
        .o_vld   (w_uvld),
        .o_nz    (w_unz),
        .o_ux    (w_ux),
        .o_uy    (w_uy),
        .o_uz    (w_uz),
        .o_pay   (w_upay)
    );

    // result beat; a zero vector already comes out as zeros
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= w_uvld;
        end
        if (w_upay[1]) begin
            r_ray.status <= ST_INVALID;
            r_ray.out_x  <= '0;
            r_ray.out_y  <= '0;
            r_ray.out_z  <= '0;
        end else begin
            r_ray.status <= w_upay[0] ? ST_TIR : ST_REFRACT;
            r_ray.out_x  <= w_unz ? 16'(64'(w_ux)) : '0;
            r_ray.out_y  <= w_unz ? 16'(64'(w_uy)) : '0;
            r_ray.out_z  <= w_unz ? 16'(64'(w_uz)) : '0;
        end
    end

    assign o_vld = r_vld;
    assign o_ray = r_ray;

endmodule

// File: sim/snell_refract_or_reflect_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snell_refract_or_reflect_test: self-checking bench for the refraction block
// Drives ray beats (directed corner cases, then random rays with random
// gaps), predicts each result in fixed point and compares it field by
// field with the beats coming out of the block, in order.
// ----------------------------------------------------------------------------
module snell_refract_or_reflect_test;
    import srr_pkg::*;

    localparam int FRAC     = 30;
    localparam int OFRAC    = 14;
    localparam int LATENCY  = 169;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    t_ray_in  i_ray;
    logic     busy;
    logic     o_valid;
    t_ray_out o_ray;

    t_ray_in  pending_rays[$];
    t_ray_out expected_rays[$];
    int       errors = 0;
    bit       stim_done;
    bit       hold_sender;
    bit       quiet_phase;

    snell_refract_or_reflect DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_ray  (i_ray),
        .busy   (busy),
        .o_valid(o_valid),
        .o_ray  (o_ray)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // magnitude as unsigned 64-bit
    function automatic longint unsigned abs64(longint x);
        return x < 0 ? longint'(0) - x : x;
    endfunction

    // right shift rounding half away from zero
    function automatic longint round_shift(longint x, int sh);
        longint unsigned m;
        m = (abs64(x) + (64'd1 << (sh - 1))) >> sh;
        return x < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // scale a vector to unit length in Q(frac); zero vector returns 0
    function automatic bit to_unit(input longint v[3], output longint u[3], input int frac);
        longint unsigned m[3];
        longint unsigned top;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned q;
        top = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = abs64(v[i]);
            if (m[i] > top) top = m[i];
            u[i] = 0;
        end
        if (top == 0) return 1'b0;
        while (top >= (64'd1 << 31)) begin
            for (int i = 0; i < 3; i++) m[i] >>= 1;
            top >>= 1;
        end
        while (top < (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) m[i] <<= 1;
            top <<= 1;
        end
        for (int i = 0; i < 3; i++) sum += m[i] * m[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << frac) + (len >> 1)) / len;
            if (q > (64'd1 << frac)) q = 64'd1 << frac;
            u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic longint i_ray_sx(logic signed [15:0] v);
        return longint'(v);
    endfunction

    // outgoing direction and status for one ray
    function automatic t_ray_out trace_ray(t_ray_in r);
        t_ray_out        res;
        longint          dv[3], nv[3], du[3], nu[3], mo[3], w[3], ov[3];
        longint          dotp, c, root, coeff, coeff30;
        longint unsigned ni, no, c2, s30, lhs, no2s, k2;
        bit              okd, okn;
        res = '0;
        dv[0] = i_ray_sx(r.dir_x);    dv[1] = i_ray_sx(r.dir_y);    dv[2] = i_ray_sx(r.dir_z);
        nv[0] = i_ray_sx(r.normal_x); nv[1] = i_ray_sx(r.normal_y); nv[2] = i_ray_sx(r.normal_z);
        ni = r.index_in;
        no = r.index_out;
        okd = to_unit(dv, du, FRAC);
        okn = to_unit(nv, nu, FRAC);
        if (ni == 0 || no == 0 || !okd || !okn) begin
            res.status = ST_INVALID;
            return res;
        end
        dotp = 0;
        for (int i = 0; i < 3; i++) dotp += du[i] * nu[i];
        for (int i = 0; i < 3; i++) mo[i] = dotp > 0 ? -nu[i] : nu[i];
        c = (abs64(dotp) + (64'd1 << (FRAC - 1))) >> FRAC;
        if (c > (64'sd1 <<< FRAC)) c = 64'sd1 <<< FRAC;
        c2   = c * c;
        s30  = (((64'd1 << (2 * FRAC)) - c2) + (64'd1 << (FRAC - 1))) >> FRAC;
        lhs  = ni * ni * s30;
        no2s = (no * no) << FRAC;
        if (ni > no && lhs > no2s) begin
            res.status = ST_TIR;
            for (int i = 0; i < 3; i++) w[i] = du[i] + round_shift(2 * c * mo[i], FRAC);
        end else begin
            res.status = ST_REFRACT;
            k2      = lhs > no2s ? 0 : no2s - lhs;
            root    = longint'(int_sqrt(k2));
            coeff   = longint'(ni) * c - (root <<< 15);
            coeff30 = round_shift(coeff, 13);
            for (int i = 0; i < 3; i++)
                w[i] = round_shift(longint'(ni) * du[i], 13) + round_shift(coeff30 * mo[i], FRAC);
        end
        void'(to_unit(w, ov, OFRAC));
        res.out_x = ov[0][15:0];
        res.out_y = ov[1][15:0];
        res.out_z = ov[2][15:0];
        return res;
    endfunction

    function automatic t_ray_in make_ray(int dx, int dy, int dz, int nx, int ny, int nz,
                                         int ni, int no);
        t_ray_in r;
        r.dir_x = dx[15:0];    r.dir_y = dy[15:0];    r.dir_z = dz[15:0];
        r.normal_x = nx[15:0]; r.normal_y = ny[15:0]; r.normal_z = nz[15:0];
        r.index_in = ni[15:0]; r.index_out = no[15:0];
        return r;
    endfunction

    // random vector component: moderate half the time, else full range or tiny
    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 65535));
            1:       return 16'($signed($urandom_range(0, 16)) - 8);
            default: return 16'($signed($urandom_range(0, 8000)) - 4000);
        endcase
    endfunction

    function automatic logic [15:0] rand_index();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom_range(0, 65535));
            1:       return 16'd0;
            default: return 16'($urandom_range(8192, 20000));  // 1.0 .. ~2.4
        endcase
    endfunction

    // stimulus
    initial begin
        t_ray_in r;
        i_rst_n     = 1'b0;
        hold_sender = 1'b0;
        quiet_phase = 1'b0;
        stim_done   = 1'b0;
        // directed corners
        pending_rays.push_back(make_ray(0, 0, -100, 0, 0, 1, 8192, 12288));
        pending_rays.push_back(make_ray(3, 0, -4, 0, 0, 5, 12288, 8192));
        pending_rays.push_back(make_ray(10, 0, -1, 0, 0, 1, 12288, 8192));    // TIR
        pending_rays.push_back(make_ray(10, 0, -1, 0, 0, -1, 12288, 8192));   // normal flip
        pending_rays.push_back(make_ray(1, 0, 0, 0, 0, 1, 8192, 8192));       // perpendicular
        pending_rays.push_back(make_ray(1, 0, 0, 0, 0, 1, 12288, 8192));
        pending_rays.push_back(make_ray(0, 0, 0, 0, 0, 1, 8192, 8192));       // zero dir
        pending_rays.push_back(make_ray(1, 2, 3, 0, 0, 0, 8192, 8192));       // zero normal
        pending_rays.push_back(make_ray(1, 2, 3, 0, 0, 1, 0, 8192));          // zero index
        pending_rays.push_back(make_ray(1, 2, 3, 0, 0, 1, 8192, 0));
        pending_rays.push_back(make_ray(-32768, -32768, -32768, 32767, 32767, 32767,
                                        65535, 1));
        pending_rays.push_back(make_ray(32767, -32768, 32767, -32768, 32767, -32768,
                                        1, 65535));
        pending_rays.push_back(make_ray(-1, -1, -1, 1, 1, 1, 65535, 65535));
        pending_rays.push_back(make_ray(0, 0, 1, 0, 0, 1, 8192, 8192));       // straight back
        pending_rays.push_back(make_ray(1, 0, -1, 0, 0, 1, 11585, 8192));     // near critical
        pending_rays.push_back(make_ray(-32768, 0, 0, 0, -32768, 0, 32768, 16384));
        pending_rays.push_back(make_ray(-5, 7, -3, 2, -9, 4, 10000, 16000));
        for (int k = 0; k < 1150; k++) begin
            r.dir_x = rand_comp(); r.dir_y = rand_comp(); r.dir_z = rand_comp();
            r.normal_x = rand_comp(); r.normal_y = rand_comp(); r.normal_z = rand_comp();
            r.index_in  = rand_index();
            r.index_out = rand_index();
            pending_rays.push_back(r);
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // drain pause midway
        wait (pending_rays.size() < 700);
        @(posedge i_clk);
        hold_sender <= 1'b1;
        wait (expected_rays.size() == 0);
        @(posedge i_clk);
        hold_sender <= 1'b0;
        // stretch with no gaps
        wait (pending_rays.size() < 400);
        quiet_phase = 1'b1;
        wait (pending_rays.size() < 250);
        quiet_phase = 1'b0;
        wait (pending_rays.size() == 0 && !start);
        wait (expected_rays.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
        stim_done = 1'b1;
    end

    // ray driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_ray <= '0;
        end else begin
            if (start && !busy) begin
                expected_rays.push_back(trace_ray(i_ray));
            end
            if (!(start && busy)) begin
                if (pending_rays.size() > 0 && !hold_sender &&
                    (quiet_phase || $urandom_range(0, 99) >= 28)) begin
                    start <= 1'b1;
                    i_ray <= pending_rays.pop_front();
                end else begin
                    start <= 1'b0;
                    i_ray <= {$urandom, $urandom, $urandom, $urandom};
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_ray_out exp_ray;
        if (i_rst_n && o_valid) begin
            if (expected_rays.size() == 0) begin
                $error("unexpected result beat: status %0d", o_ray.status);
                errors++;
            end else begin
                exp_ray = expected_rays.pop_front();
                if (o_ray.status !== exp_ray.status) begin
                    $error("status: expected %0d, got %0d", exp_ray.status, o_ray.status);
                    errors++;
                end
                if (o_ray.out_x !== exp_ray.out_x) begin
                    $error("out_x: expected %0d, got %0d", exp_ray.out_x, o_ray.out_x);
                    errors++;
                end
                if (o_ray.out_y !== exp_ray.out_y) begin
                    $error("out_y: expected %0d, got %0d", exp_ray.out_y, o_ray.out_y);
                    errors++;
                end
                if (o_ray.out_z !== exp_ray.out_z) begin
                    $error("out_z: expected %0d, got %0d", exp_ray.out_z, o_ray.out_z);
                    errors++;
                end
            end
        end
    end

    // final verdict
    initial begin
        wait (stim_done);
        if (errors == 0 && expected_rays.size() == 0) begin
            $display("snell_refract_or_reflect: match");
        end else begin
            $display("snell_refract_or_reflect: mismatch");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("snell_refract_or_reflect: mismatch");
        $finish;
    end

endmodule

// File: filelist.f
src/srr_pkg.sv
src/srr_isqrt.sv
src/srr_unitize.sv
src/srr_front.sv
src/srr_queue.sv
src/srr_back.sv
src/snell_refract_or_reflect.sv
sim/snell_refract_or_reflect_test.sv
